// File: rtl/ihm_pkg.sv
package ihm_pkg;

  // Fixed field widths of the stream channels.
  localparam int unsigned OP_W       = 2;
  localparam int unsigned KEY_W      = 32;
  localparam int unsigned HANDLE_W   = 10;
  localparam int unsigned COUNT_W    = 10;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 56;

  // Operation codes carried on the input tuser.
  typedef enum logic [OP_W-1:0] {
    OP_LOAD     = 2'd0,
    OP_EXTRACT  = 2'd1,
    OP_DECREASE = 2'd2,
    OP_INSERT   = 2'd3
  } op_e;

  // Status codes carried on the output tuser.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_e;

endpackage

// File: rtl/ihm_ram.sv
module ihm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/indexed_min_heap_unit.sv
// Indexed binary min-heap with a handle-to-slot map.
// Input channel (s_axis): tuser carries the operation (load, extract-min,
// decrease-key, insert), tdata the key and handle, tlast marks the final
// element of a load, which builds the heap bottom-up.
// Output channel (m_axis): exactly one item per input item, carrying the
// handle, key and element count in tdata and the status in tuser.
// Each item is worked on alone; s_axis_tready is high only while the
// sequencer is idle. On the way down a sift works each heap level in steps:
// left child read, right child read if there is one, compare and move, and
// next level check; on the way up it reads and moves the parent. The steps
// are set by the single read port of the key and handle memories.
// The result sits in an output register, so the next item is accepted while
// a finished result waits; a stalled receiver only holds the sequencer at its
// last step, once the next result is ready.
// Reset clears the count and the load fill; the memories are not cleared, as
// no result reads an entry that was never written.
module indexed_min_heap_unit
  import ihm_pkg::*;
#(
  parameter int unsigned CAPACITY = 1023,
  parameter int unsigned KEY_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // key[31:0], handle[41:32], zeros
  input  logic [OP_W-1:0]       s_axis_tuser,  // op[1:0]
  input  logic                  s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,  // handle_out[9:0], key_out[41:10],
                                               // count[51:42], zeros
  output logic [STATUS_W-1:0]   m_axis_tuser   // status[1:0]
);

  localparam int unsigned SLOTS  = CAPACITY + 1;
  localparam int unsigned SLOT_W = $clog2(SLOTS);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_BUILD_RD = 4'd1;
  localparam logic [3:0] S_BUILD_LD = 4'd2;
  localparam logic [3:0] S_DN_CHK   = 4'd3;
  localparam logic [3:0] S_DN_RL    = 4'd4;
  localparam logic [3:0] S_DN_RR    = 4'd5;
  localparam logic [3:0] S_DN_CMP   = 4'd6;
  localparam logic [3:0] S_UP_CHK   = 4'd7;
  localparam logic [3:0] S_UP_RD    = 4'd8;
  localparam logic [3:0] S_FIN      = 4'd9;
  localparam logic [3:0] S_EX_R1    = 4'd10;
  localparam logic [3:0] S_EX_RN    = 4'd11;
  localparam logic [3:0] S_EX_W2    = 4'd12;
  localparam logic [3:0] S_DK_R1    = 4'd13;
  localparam logic [3:0] S_DK_R2    = 4'd14;
  localparam logic [3:0] S_DONE     = 4'd15;

  logic [3:0] state_q, state_d;

  // Control registers.
  logic [SLOT_W-1:0] count_q, count_d;
  logic [SLOT_W-1:0] fill_q, fill_d;
  logic [SLOT_W-1:0] i_q, i_d;
  logic [SLOT_W-1:0] b_q, b_d;
  logic              up_q, up_d;
  logic              build_q, build_d;
  logic              moved_q, moved_d;
  logic              rok_q, rok_d;
  logic              out_valid_q, out_valid_d;

  // Payload registers.
  logic [KEY_BITS-1:0] xk_q, xk_d;
  logic [SLOT_W-1:0]   xh_q, xh_d;
  logic [KEY_BITS-1:0] kl_q, kl_d, kr_q, kr_d;
  logic [SLOT_W-1:0]   hl_q, hl_d, hr_q, hr_d;
  logic [KEY_BITS-1:0] in_key_q, in_key_d;
  logic [HANDLE_W-1:0] in_handle_q, in_handle_d;
  logic [HANDLE_W-1:0] res_h_q, res_h_d;
  logic [KEY_W-1:0]    res_k_q, res_k_d;
  status_e             res_st_q, res_st_d;
  logic [HANDLE_W-1:0] out_h_q, out_h_d;
  logic [KEY_W-1:0]    out_k_q, out_k_d;
  logic [COUNT_W-1:0]  out_c_q, out_c_d;
  status_e             out_st_q, out_st_d;

  // Memory ports.
  logic                kh_we;
  logic [SLOT_W-1:0]   kh_waddr, kh_raddr;
  logic [KEY_BITS-1:0] key_wdata, key_rdata;
  logic [SLOT_W-1:0]   hos_wdata, hos_rdata;
  logic                soh_we;
  logic [SLOT_W-1:0]   soh_waddr, soh_wdata, soh_raddr, soh_rdata;

  // Input fields.
  op_e                 in_op;
  logic [KEY_BITS-1:0] in_key;
  logic [HANDLE_W-1:0] in_handle;
  logic                in_accept;

  // Sift helpers.
  logic [SLOT_W:0]     l_pos, r_pos, n_ext;
  logic [SLOT_W-1:0]   new_slot;
  logic [KEY_BITS-1:0] min_lk;
  logic                sel_l, sel_r;

  assign in_op     = op_e'(s_axis_tuser);
  assign in_key    = KEY_BITS'(s_axis_tdata[KEY_W-1:0]);
  assign in_handle = s_axis_tdata[KEY_W+HANDLE_W-1:KEY_W];
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_accept = s_axis_tvalid && s_axis_tready;

  assign l_pos = {i_q, 1'b0};
  assign r_pos = {i_q, 1'b1};
  assign n_ext = {1'b0, count_q};
  assign new_slot = count_q + 1'b1;

  // Child selection for one level of the downward sift.
  assign sel_l  = kl_q < xk_q;
  assign min_lk = sel_l ? kl_q : xk_q;
  assign sel_r  = rok_q && (kr_q < min_lk);

  // Storage: key and handle per slot, and slot per handle.
  ihm_ram #(.WIDTH(KEY_BITS), .DEPTH(SLOTS)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (kh_we),
    .waddr_i (kh_waddr),
    .wdata_i (key_wdata),
    .raddr_i (kh_raddr),
    .rdata_o (key_rdata)
  );

  ihm_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_hos_ram (
    .clk_i   (clk_i),
    .we_i    (kh_we),
    .waddr_i (kh_waddr),
    .wdata_i (hos_wdata),
    .raddr_i (kh_raddr),
    .rdata_o (hos_rdata)
  );

  ihm_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_soh_ram (
    .clk_i   (clk_i),
    .we_i    (soh_we),
    .waddr_i (soh_waddr),
    .wdata_i (soh_wdata),
    .raddr_i (soh_raddr),
    .rdata_o (soh_rdata)
  );

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    fill_d      = fill_q;
    i_d         = i_q;
    b_d         = b_q;
    up_d        = up_q;
    build_d     = build_q;
    moved_d     = moved_q;
    rok_d       = rok_q;
    xk_d        = xk_q;
    xh_d        = xh_q;
    kl_d        = kl_q;
    hl_d        = hl_q;
    kr_d        = kr_q;
    hr_d        = hr_q;
    in_key_d    = in_key_q;
    in_handle_d = in_handle_q;
    res_h_d     = res_h_q;
    res_k_d     = res_k_q;
    res_st_d    = res_st_q;
    out_valid_d = out_valid_q;
    out_h_d     = out_h_q;
    out_k_d     = out_k_q;
    out_c_d     = out_c_q;
    out_st_d    = out_st_q;
    kh_we       = 1'b0;
    kh_waddr    = '0;
    key_wdata   = '0;
    hos_wdata   = '0;
    kh_raddr    = '0;
    soh_we      = 1'b0;
    soh_waddr   = '0;
    soh_wdata   = '0;
    soh_raddr   = '0;

    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          in_key_d    = in_key;
          in_handle_d = in_handle;
          res_h_d     = '0;
          res_k_d     = '0;
          res_st_d    = ST_OK;
          build_d     = 1'b0;
          if (in_op != OP_LOAD) begin
            fill_d = '0;
          end
          unique case (in_op)
            OP_LOAD: begin
              count_d = '0;
              if (32'(fill_q) >= CAPACITY) begin
                res_st_d = ST_OVERFLOW;
                fill_d   = fill_q;
              end else begin
                fill_d    = fill_q + 1'b1;
                kh_we     = 1'b1;
                kh_waddr  = fill_d;
                key_wdata = in_key;
                hos_wdata = fill_d;
                soh_we    = 1'b1;
                soh_waddr = fill_d;
                soh_wdata = fill_d;
                res_h_d   = HANDLE_W'(fill_d);
                res_k_d   = KEY_W'(in_key);
              end
              if (s_axis_tlast) begin
                count_d = fill_d;
                b_d     = fill_d >> 1;
                fill_d  = '0;
                build_d = 1'b1;
                state_d = S_BUILD_RD;
              end else begin
                state_d = S_DONE;
              end
            end
            OP_EXTRACT: begin
              if (count_q == '0) begin
                res_st_d = ST_UNDERFLOW;
                state_d  = S_DONE;
              end else begin
                kh_raddr = SLOT_W'(1);
                state_d  = S_EX_R1;
              end
            end
            OP_DECREASE: begin
              res_h_d = in_handle;
              if (32'(in_handle) < SLOTS) begin
                soh_raddr = SLOT_W'(in_handle);
                state_d   = S_DK_R1;
              end else begin
                state_d = S_DONE;
              end
            end
            default: begin
              if (32'(count_q) >= CAPACITY) begin
                res_st_d = ST_OVERFLOW;
                state_d  = S_DONE;
              end else begin
                count_d = new_slot;
                xk_d    = in_key;
                xh_d    = new_slot;
                i_d     = new_slot;
                up_d    = 1'b1;
                res_h_d = HANDLE_W'(new_slot);
                res_k_d = KEY_W'(in_key);
                state_d = S_UP_CHK;
              end
            end
          endcase
        end
      end

      // Bottom-up build: sift each inner slot down, last parent first.
      S_BUILD_RD: begin
        if (b_q == '0) begin
          state_d = S_DONE;
        end else begin
          kh_raddr = b_q;
          state_d  = S_BUILD_LD;
        end
      end
      S_BUILD_LD: begin
        xk_d    = key_rdata;
        xh_d    = hos_rdata;
        i_d     = b_q;
        moved_d = 1'b0;
        up_d    = 1'b0;
        state_d = S_DN_CHK;
      end

      // Downward sift: read one or both children, then move the smaller one up.
      S_DN_CHK: begin
        if (l_pos > n_ext) begin
          state_d = S_FIN;
        end else begin
          kh_raddr = l_pos[SLOT_W-1:0];
          state_d  = S_DN_RL;
        end
      end
      S_DN_RL: begin
        kl_d  = key_rdata;
        hl_d  = hos_rdata;
        rok_d = (r_pos <= n_ext);
        if (r_pos <= n_ext) begin
          kh_raddr = r_pos[SLOT_W-1:0];
          state_d  = S_DN_RR;
        end else begin
          state_d = S_DN_CMP;
        end
      end
      S_DN_RR: begin
        kr_d    = key_rdata;
        hr_d    = hos_rdata;
        state_d = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (sel_r || sel_l) begin
          kh_we     = 1'b1;
          kh_waddr  = i_q;
          key_wdata = sel_r ? kr_q : kl_q;
          hos_wdata = sel_r ? hr_q : hl_q;
          soh_we    = 1'b1;
          soh_waddr = hos_wdata;
          soh_wdata = i_q;
          i_d       = sel_r ? r_pos[SLOT_W-1:0] : l_pos[SLOT_W-1:0];
          moved_d   = 1'b1;
          state_d   = S_DN_CHK;
        end else begin
          state_d = S_FIN;
        end
      end

      // Upward sift: move the parent down while it is larger.
      S_UP_CHK: begin
        if (i_q <= SLOT_W'(1)) begin
          state_d = S_FIN;
        end else begin
          kh_raddr = i_q >> 1;
          state_d  = S_UP_RD;
        end
      end
      S_UP_RD: begin
        if (key_rdata > xk_q) begin
          kh_we     = 1'b1;
          kh_waddr  = i_q;
          key_wdata = key_rdata;
          hos_wdata = hos_rdata;
          soh_we    = 1'b1;
          soh_waddr = hos_rdata;
          soh_wdata = i_q;
          i_d       = i_q >> 1;
          state_d   = S_UP_CHK;
        end else begin
          state_d = S_FIN;
        end
      end

      // Place the held element in its final slot.
      S_FIN: begin
        kh_we     = 1'b1;
        kh_waddr  = i_q;
        key_wdata = xk_q;
        hos_wdata = xh_q;
        soh_we    = up_q || moved_q;
        soh_waddr = xh_q;
        soh_wdata = i_q;
        if (build_q) begin
          b_d     = b_q - 1'b1;
          state_d = S_BUILD_RD;
        end else begin
          state_d = S_DONE;
        end
      end

      // Extract: take the root, swap the last slot in, then sift down.
      S_EX_R1: begin
        res_h_d  = HANDLE_W'(hos_rdata);
        res_k_d  = KEY_W'(key_rdata);
        kl_d     = key_rdata;
        hl_d     = hos_rdata;
        kh_raddr = count_q;
        state_d  = S_EX_RN;
      end
      S_EX_RN: begin
        xk_d      = key_rdata;
        xh_d      = hos_rdata;
        kh_we     = 1'b1;
        kh_waddr  = count_q;
        key_wdata = kl_q;
        hos_wdata = hl_q;
        soh_we    = 1'b1;
        soh_waddr = hos_rdata;
        soh_wdata = SLOT_W'(1);
        state_d   = S_EX_W2;
      end
      S_EX_W2: begin
        soh_we    = 1'b1;
        soh_waddr = hl_q;
        soh_wdata = count_q;
        count_d   = count_q - 1'b1;
        i_d       = SLOT_W'(1);
        moved_d   = 1'b0;
        up_d      = 1'b0;
        state_d   = S_DN_CHK;
      end

      // Decrease-key: check that the handle maps to a live slot that owns it.
      S_DK_R1: begin
        if ((soh_rdata != '0) && (soh_rdata <= count_q)) begin
          kh_raddr = soh_rdata;
          i_d      = soh_rdata;
          state_d  = S_DK_R2;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DK_R2: begin
        if (32'(hos_rdata) == 32'(in_handle_q)) begin
          xk_d    = in_key_q;
          xh_d    = hos_rdata;
          up_d    = 1'b1;
          res_k_d = KEY_W'(in_key_q);
          state_d = S_UP_CHK;
        end else begin
          state_d = S_DONE;
        end
      end

      // Hand the result to the output register once it is free.
      S_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_h_d     = res_h_q;
          out_k_d     = res_k_q;
          out_c_d     = COUNT_W'(count_q);
          out_st_d    = res_st_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      fill_q      <= '0;
      i_q         <= '0;
      b_q         <= '0;
      up_q        <= 1'b0;
      build_q     <= 1'b0;
      moved_q     <= 1'b0;
      rok_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      fill_q      <= fill_d;
      i_q         <= i_d;
      b_q         <= b_d;
      up_q        <= up_d;
      build_q     <= build_d;
      moved_q     <= moved_d;
      rok_q       <= rok_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload.
  always_ff @(posedge clk_i) begin
    xk_q        <= xk_d;
    xh_q        <= xh_d;
    kl_q        <= kl_d;
    hl_q        <= hl_d;
    kr_q        <= kr_d;
    hr_q        <= hr_d;
    in_key_q    <= in_key_d;
    in_handle_q <= in_handle_d;
    res_h_q     <= res_h_d;
    res_k_q     <= res_k_d;
    res_st_q    <= res_st_d;
    out_h_q     <= out_h_d;
    out_k_q     <= out_k_d;
    out_c_q     <= out_c_d;
    out_st_q    <= out_st_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, out_c_q, out_k_q, out_h_q};
  assign m_axis_tuser  = out_st_q;

endmodule

// File: rtl/ihm_checker.sv
module ihm_checker
  import ihm_pkg::*;
#(
  parameter int unsigned CAPACITY = 1023
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic [STATUS_W-1:0]   m_axis_tuser
);

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // Each item is worked on alone, so no item is taken right after another.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while an item is in work");

  // Only the three defined status codes appear.
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser != STATUS_W'(3))
    else $error("undefined status");

  // An underflow reports an empty heap and a zero item.
  a_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_UNDERFLOW) |-> m_axis_tdata == '0)
    else $error("underflow with a non-zero item");

  // The reported count never exceeds the capacity.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> 32'(m_axis_tdata[51:42]) <= CAPACITY)
    else $error("count beyond capacity");

endmodule

bind indexed_min_heap_unit ihm_checker #(.CAPACITY(CAPACITY)) u_ihm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// File: dv/indexed_min_heap_unit_test.sv
`timescale 1ns / 1ps

module indexed_min_heap_unit_test;
  import ihm_pkg::*;

  localparam int unsigned CAP   = 1023;
  localparam int unsigned SLOTS = CAP + 1;
  localparam logic [KEY_W-1:0] KEY_MAX = '1;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [KEY_W-1:0]    key;
    logic [COUNT_W-1:0]  count;
    status_e             status;
  } heap_result_t;

  typedef struct {
    op_e                 op;
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
    logic                last;
    logic                fixed;
    heap_result_t        result;
  } stim_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [OP_W-1:0]       s_axis_tuser = '0;
  logic                  s_axis_tlast = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [STATUS_W-1:0]   m_axis_tuser;

  indexed_min_heap_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Shadow copy of the heap, kept in step with accepted items.
  logic [KEY_W-1:0]    slot_key    [SLOTS];
  logic [HANDLE_W-1:0] slot_handle [SLOTS];
  int unsigned         handle_slot [SLOTS];
  bit                  handle_seen [SLOTS];
  int unsigned         heap_cnt;
  int unsigned         fill_cnt;

  heap_result_t pending_q[$];
  int unsigned  error_cnt;
  int unsigned  idle_pct;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end

  task automatic log_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    error_cnt++;
  endtask

  function automatic void swap_slots(input int unsigned a, input int unsigned b);
    logic [KEY_W-1:0]    k;
    logic [HANDLE_W-1:0] h;
    k = slot_key[a];
    h = slot_handle[a];
    slot_key[a] = slot_key[b];
    slot_key[b] = k;
    slot_handle[a] = slot_handle[b];
    slot_handle[b] = h;
    handle_slot[slot_handle[a]] = a;
    handle_slot[slot_handle[b]] = b;
  endfunction

  function automatic void sift_down(input int unsigned i);
    int unsigned s;
    forever begin
      s = i;
      if (2 * i <= heap_cnt && slot_key[2 * i] < slot_key[s]) s = 2 * i;
      if (2 * i + 1 <= heap_cnt && slot_key[2 * i + 1] < slot_key[s]) s = 2 * i + 1;
      if (s == i) return;
      swap_slots(i, s);
      i = s;
    end
  endfunction

  function automatic void sift_up(input int unsigned i);
    while (i > 1 && slot_key[i / 2] > slot_key[i]) begin
      swap_slots(i, i / 2);
      i = i / 2;
    end
  endfunction

  // Applies one item to the shadow heap and returns the result it must give.
  function automatic heap_result_t heap_apply(input op_e op, input logic [KEY_W-1:0] key,
                                              input logic [HANDLE_W-1:0] handle,
                                              input logic last);
    heap_result_t r;
    int unsigned  s;
    r = '{handle: '0, key: '0, count: '0, status: ST_OK};
    if (op != OP_LOAD) fill_cnt = 0;
    case (op)
      OP_LOAD: begin
        if (fill_cnt >= CAP) begin
          r.status = ST_OVERFLOW;
        end else begin
          fill_cnt++;
          slot_key[fill_cnt] = key;
          slot_handle[fill_cnt] = HANDLE_W'(fill_cnt);
          handle_slot[fill_cnt] = fill_cnt;
          handle_seen[fill_cnt] = 1'b1;
          r.handle = HANDLE_W'(fill_cnt);
          r.key = key;
        end
        heap_cnt = 0;
        if (last) begin
          heap_cnt = fill_cnt;
          fill_cnt = 0;
          for (int i = heap_cnt / 2; i >= 1; i--) sift_down(i);
        end
      end
      OP_EXTRACT: begin
        if (heap_cnt == 0) begin
          r.status = ST_UNDERFLOW;
        end else begin
          r.handle = slot_handle[1];
          r.key = slot_key[1];
          swap_slots(1, heap_cnt);
          heap_cnt--;
          sift_down(1);
        end
      end
      OP_DECREASE: begin
        r.handle = handle;
        s = handle_slot[handle];
        if (s >= 1 && s <= heap_cnt && slot_handle[s] == handle) begin
          slot_key[s] = key;
          r.key = key;
          sift_up(s);
        end
      end
      default: begin
        if (heap_cnt >= CAP) begin
          r.status = ST_OVERFLOW;
        end else begin
          heap_cnt++;
          slot_key[heap_cnt] = key;
          slot_handle[heap_cnt] = HANDLE_W'(heap_cnt);
          handle_slot[heap_cnt] = heap_cnt;
          handle_seen[heap_cnt] = 1'b1;
          sift_up(heap_cnt);
          r.handle = HANDLE_W'(heap_cnt);
          r.key = key;
        end
      end
    endcase
    r.count = COUNT_W'(heap_cnt);
    return r;
  endfunction

  // Offers one item, waits for it to be taken, and queues its result.
  task automatic send_item(input op_e op, input logic [KEY_W-1:0] key,
                           input logic [HANDLE_W-1:0] handle, input logic last,
                           input logic fixed = 1'b0,
                           input heap_result_t fixed_res = '0);
    heap_result_t r;
    if ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {6'd0, handle, key};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    r = heap_apply(op, key, handle, last);
    pending_q.push_back(fixed ? fixed_res : r);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: checks each result item against the oldest expectation.
  always @(posedge clk_i) begin
    heap_result_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = '{handle: m_axis_tdata[9:0], key: m_axis_tdata[41:10],
              count: m_axis_tdata[51:42], status: status_e'(m_axis_tuser)};
      if (pending_q.size() == 0) begin
        log_mismatch("result item with nothing expected");
      end else begin
        want = pending_q.pop_front();
        if (got.handle !== want.handle)
          log_mismatch($sformatf("handle %0d, expected %0d", got.handle, want.handle));
        if (got.key !== want.key)
          log_mismatch($sformatf("key %0h, expected %0h", got.key, want.key));
        if (got.count !== want.count)
          log_mismatch($sformatf("count %0d, expected %0d", got.count, want.count));
        if (got.status !== want.status)
          log_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
      end
    end
    m_axis_tready <= ($urandom_range(99) >= idle_pct);
  end

  stim_row_t directed[] = '{
    '{OP_EXTRACT,  32'h0,        10'd0,   1'b0, 1'b1, '{10'd0, 32'h0, 10'd0, ST_UNDERFLOW}},
    '{OP_LOAD,     32'hFFFFFFFF, 10'd0,   1'b0, 1'b1, '{10'd1, 32'hFFFFFFFF, 10'd0, ST_OK}},
    '{OP_LOAD,     32'h0,        10'd0,   1'b0, 1'b1, '{10'd2, 32'h0, 10'd0, ST_OK}},
    '{OP_LOAD,     32'h5,        10'd0,   1'b0, 1'b1, '{10'd3, 32'h5, 10'd0, ST_OK}},
    '{OP_LOAD,     32'h7,        10'd0,   1'b1, 1'b1, '{10'd4, 32'h7, 10'd4, ST_OK}},
    '{OP_EXTRACT,  32'h0,        10'd0,   1'b0, 1'b1, '{10'd2, 32'h0, 10'd3, ST_OK}},
    '{OP_DECREASE, 32'h3,        10'd1,   1'b0, 1'b0, '0},
    '{OP_DECREASE, 32'hFFFFFFFF, 10'd1,   1'b0, 1'b0, '0},
    '{OP_DECREASE, 32'h1,        10'd2,   1'b0, 1'b0, '0},
    '{OP_INSERT,   32'h0,        10'd0,   1'b0, 1'b0, '0},
    '{OP_INSERT,   32'hFFFFFFFF, 10'd0,   1'b0, 1'b0, '0},
    '{OP_DECREASE, 32'h2,        10'd4,   1'b0, 1'b0, '0},
    '{OP_EXTRACT,  32'h0,        10'd0,   1'b0, 1'b0, '0},
    '{OP_EXTRACT,  32'h0,        10'd0,   1'b0, 1'b0, '0},
    '{OP_EXTRACT,  32'h0,        10'd0,   1'b0, 1'b0, '0},
    '{OP_LOAD,     32'h9,        10'd0,   1'b0, 1'b1, '{10'd1, 32'h9, 10'd0, ST_OK}},
    '{OP_EXTRACT,  32'h0,        10'd0,   1'b0, 1'b1, '{10'd0, 32'h0, 10'd0, ST_UNDERFLOW}},
    '{OP_LOAD,     32'h1,        10'd0,   1'b1, 1'b1, '{10'd1, 32'h1, 10'd1, ST_OK}},
    '{OP_EXTRACT,  32'h0,        10'd0,   1'b0, 1'b1, '{10'd1, 32'h1, 10'd0, ST_OK}}
  };

  function automatic logic [KEY_W-1:0] rand_key();
    case ($urandom_range(9))
      0:       return '0;
      1:       return KEY_MAX;
      2:       return $urandom_range(15);
      default: return $urandom;
    endcase
  endfunction

  // Picks a handle that has been written, mostly one still in the heap.
  function automatic logic [HANDLE_W-1:0] pick_handle();
    int unsigned h;
    if (heap_cnt != 0 && $urandom_range(9) < 8) return slot_handle[$urandom_range(1, heap_cnt)];
    for (int n = 0; n < 64; n++) begin
      h = $urandom_range(1, SLOTS - 1);
      if (handle_seen[h]) return HANDLE_W'(h);
    end
    return 10'd1;
  endfunction

  initial begin
    int unsigned         sent;
    int unsigned         n_load;
    int unsigned         n_ops;
    int unsigned         pick;
    logic [HANDLE_W-1:0] h;
    error_cnt = 0;
    heap_cnt = 0;
    fill_cnt = 0;
    idle_pct = 32;
    foreach (handle_seen[i]) begin
      handle_seen[i] = 1'b0;
      handle_slot[i] = 0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows: extremes, every operation and the corner cases.
    foreach (directed[i])
      send_item(directed[i].op, directed[i].key, directed[i].handle, directed[i].last,
                directed[i].fixed, directed[i].result);

    // Full load with one element too many, then insert into a full heap, a decrease-key and a run of extracts.
    drain_results();
    for (int i = 1; i <= SLOTS; i++) send_item(OP_LOAD, rand_key(), '0, i == SLOTS);
    send_item(OP_INSERT, $urandom, '0, 1'b0);
    send_item(OP_DECREASE, 32'h0, 10'd1023, 1'b0);
    repeat (40) send_item(OP_EXTRACT, '0, '0, 1'b0);

    // Random phases: a small load followed by a mix of heap operations.
    sent = 0;
    while (sent < 650) begin
      idle_pct = (sent >= 200 && sent < 450) ? 0 : 32;
      n_load = $urandom_range(1, 40);
      for (int i = 1; i <= n_load; i++) begin
        send_item(OP_LOAD, rand_key(), 10'($urandom), i == n_load && $urandom_range(9) != 0);
        sent++;
      end
      n_ops = $urandom_range(10, 60);
      for (int i = 0; i < n_ops; i++) begin
        pick = $urandom_range(99);
        if (pick < 35) begin
          send_item(OP_EXTRACT, 32'($urandom), 10'($urandom), 1'($urandom));
        end else if (pick < 70) begin
          h = pick_handle();
          if ($urandom_range(9) < 8 && handle_slot[h] >= 1 && handle_slot[h] <= heap_cnt)
            send_item(OP_DECREASE, $urandom_range(0, slot_key[handle_slot[h]]), h, 1'($urandom));
          else
            send_item(OP_DECREASE, rand_key(), h, 1'($urandom));
        end else begin
          send_item(OP_INSERT, rand_key(), 10'($urandom), 1'($urandom));
        end
        sent++;
      end
    end

    drain_results();
    repeat (300) @(posedge clk_i);
    if (error_cnt == 0 && pending_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
